// ===== hw/rtl/rdmc_pkg.sv =====
// Shared types, register indexes and constants of the drive mode controller.
// No dependencies; every other file but rdmc_if imports this package.
`default_nettype none

package rdmc_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_STOP   = 2'd3
  } mode_t;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_MAX   = 3'd4;

  localparam logic [12:0]        RST_STOP_DIST = 13'd120;
  localparam logic [15:0]        RST_STOP_HOLD = 16'd800;
  localparam logic signed [10:0] RST_REV_SPEED = -11'sd70;
  localparam logic [10:0]        RST_LIN_MAX   = 11'd120;
  localparam logic [12:0]        RST_ANG_MAX   = 13'd500;

  // stick scaling: q = (|stick| * max + 63) / 127
  // divide by reciprocal: floor(x * RECIP / 2^RECIP_SH), exact for x < 2^SCL_W
  localparam int          SCL_W    = 20;
  localparam int          QUO_W    = 14;
  localparam int          RECIP_W  = 21;
  localparam int          RECIP_SH = 27;
  localparam logic [RECIP_W-1:0] RECIP = 21'd1056833;
  localparam logic [SCL_W-1:0]   ROUND_BIAS = 20'd63;

  typedef struct packed {
    logic [12:0]        stop_dist;
    logic [15:0]        stop_hold;
    logic signed [10:0] rev_speed;
    logic [10:0]        lin_max;
    logic [12:0]        ang_max;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        now_ms;
    logic               controller_connected;
    logic               link_ok;
    logic               mode_switch;
    logic signed [7:0]  stick_lin;
    logic signed [7:0]  stick_turn;
    logic signed [15:0] auto_lin_mm_s;
    logic signed [15:0] auto_ang_mrad_s;
    logic signed [13:0] range_right_mm;
    logic signed [13:0] range_center_mm;
    logic signed [13:0] range_left_mm;
  } in_item_t;

  // item after the product stage
  typedef struct packed {
    logic [15:0]        now_ms;
    logic               all_ok;
    logic               sw;
    logic               estop;
    logic signed [15:0] auto_lin;
    logic signed [15:0] auto_ang;
    logic               lin_neg;
    logic [SCL_W-1:0]   lin_arg;
    logic               turn_neg;
    logic [SCL_W-1:0]   ang_arg;
  } mid_t;

  typedef struct packed {
    mode_t              mode_now;
    logic               mode_changed;
    logic signed [15:0] lin_cmd;
    logic signed [15:0] ang_cmd;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rdmc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Field widths follow the item definitions in rdmc_pkg.
`default_nettype none

interface rdmc_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        now_ms;
  logic               controller_connected;
  logic               link_ok;
  logic               mode_switch;
  logic signed [7:0]  stick_lin;
  logic signed [7:0]  stick_turn;
  logic signed [15:0] auto_lin_mm_s;
  logic signed [15:0] auto_ang_mrad_s;
  logic signed [13:0] range_right_mm;
  logic signed [13:0] range_center_mm;
  logic signed [13:0] range_left_mm;

  modport source (
    output valid, now_ms, controller_connected, link_ok, mode_switch,
           stick_lin, stick_turn, auto_lin_mm_s, auto_ang_mrad_s,
           range_right_mm, range_center_mm, range_left_mm,
    input  ready
  );
  modport sink (
    input  valid, now_ms, controller_connected, link_ok, mode_switch,
           stick_lin, stick_turn, auto_lin_mm_s, auto_ang_mrad_s,
           range_right_mm, range_center_mm, range_left_mm,
    output ready
  );
endinterface

interface rdmc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode_now;
  logic               mode_changed;
  logic signed [15:0] lin_cmd_mm_s;
  logic signed [15:0] ang_cmd_mrad_s;

  modport source (
    output valid, mode_now, mode_changed, lin_cmd_mm_s, ang_cmd_mrad_s,
    input  ready
  );
  modport sink (
    input  valid, mode_now, mode_changed, lin_cmd_mm_s, ang_cmd_mrad_s,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/rdmc_cfg.sv =====
// Configuration register file of the drive mode controller.
// Depends on rdmc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module rdmc_cfg
  import rdmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_dist <= RST_STOP_DIST;
      cfg_r.stop_hold <= RST_STOP_HOLD;
      cfg_r.rev_speed <= RST_REV_SPEED;
      cfg_r.lin_max   <= RST_LIN_MAX;
      cfg_r.ang_max   <= RST_ANG_MAX;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STOP_DIST: cfg_r.stop_dist <= cfg_wdata[12:0];
        CFG_STOP_HOLD: cfg_r.stop_hold <= cfg_wdata[15:0];
        CFG_REV_SPEED: cfg_r.rev_speed <= cfg_wdata[10:0];
        CFG_LIN_MAX:   cfg_r.lin_max   <= cfg_wdata[10:0];
        CFG_ANG_MAX:   cfg_r.ang_max   <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdmc_prep.sv =====
// Product stage: stick magnitudes times configured maxima, obstacle check,
// connection gating. Depends on rdmc_pkg (in_item_t, mid_t, cfg_t).
`default_nettype none

module rdmc_prep
  import rdmc_pkg::*;
(
  input  in_item_t item,
  input  cfg_t     cfg,
  output mid_t     mid
);

  function automatic logic near_hit(input logic signed [13:0] r, input logic [12:0] thr);
    return !r[13] && (r[12:0] < thr);
  endfunction

  logic              ctrl;
  logic signed [7:0] sl, st;
  logic [7:0]        lin_mag, turn_mag;
  logic [18:0]       lin_prod;
  logic [19:0]       ang_prod;

  always_comb begin
    ctrl = item.controller_connected;
    // a disconnected controller reads as centered sticks
    sl = ctrl ? item.stick_lin  : 8'sd0;
    st = ctrl ? item.stick_turn : 8'sd0;
    // -128 becomes 128 as an unsigned magnitude
    lin_mag  = sl[7] ? 8'(-sl) : 8'(sl);
    turn_mag = st[7] ? 8'(-st) : 8'(st);
    lin_prod = 19'(lin_mag)  * 19'(cfg.lin_max);
    ang_prod = 20'(turn_mag) * 20'(cfg.ang_max);

    mid.now_ms   = item.now_ms;
    mid.all_ok   = ctrl && item.link_ok;
    mid.sw       = ctrl && item.mode_switch;
    mid.estop    = near_hit(item.range_right_mm,  cfg.stop_dist)
                || near_hit(item.range_center_mm, cfg.stop_dist)
                || near_hit(item.range_left_mm,   cfg.stop_dist);
    mid.auto_lin = item.auto_lin_mm_s;
    mid.auto_ang = item.auto_ang_mrad_s;
    mid.lin_neg  = sl[7];
    mid.lin_arg  = SCL_W'(lin_prod) + ROUND_BIAS;
    mid.turn_neg = st[7];
    mid.ang_arg  = ang_prod + ROUND_BIAS;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdmc_div127.sv =====
// Divide by 127 through a reciprocal multiply, exact over the scaling range.
// Depends on rdmc_pkg for SCL_W, QUO_W and the reciprocal constants.
`default_nettype none

module rdmc_div127
  import rdmc_pkg::*;
(
  input  wire logic [SCL_W-1:0] arg,
  output logic      [QUO_W-1:0] quo
);

  localparam int PW = SCL_W + RECIP_W;

  logic [PW-1:0] prod;

  assign prod = PW'(arg) * PW'(RECIP);
  assign quo  = prod[RECIP_SH +: QUO_W];

endmodule

`default_nettype wire

// ===== hw/rtl/rdmc_fsm.sv =====
// Mode state machine and drive command select; holds mode and stop start time.
// Depends on rdmc_pkg (mode_t, mid_t, cfg_t, res_t).
`default_nettype none

module rdmc_fsm
  import rdmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  mid_t                  mid,
  input  cfg_t                  cfg,
  input  wire logic [QUO_W-1:0] lin_q,
  input  wire logic [QUO_W-1:0] ang_q,
  output res_t                  res,
  output mode_t                 mode_q
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] stop_start_r, stop_start_nxt;
  logic [15:0] elapsed;
  logic signed [15:0] lin_man, ang_man;

  always_comb begin
    lin_man = mid.lin_neg  ? 16'(0) - 16'(lin_q) : 16'(lin_q);
    // turn command is the negated stick
    ang_man = mid.turn_neg ? 16'(ang_q) : 16'(0) - 16'(ang_q);
    elapsed = mid.now_ms - stop_start_r;

    mode_nxt       = mode_r;
    stop_start_nxt = stop_start_r;
    res.lin_cmd    = '0;
    res.ang_cmd    = '0;

    unique case (mode_r)
      MODE_IDLE: begin
        if (mid.all_ok) mode_nxt = MODE_MANUAL;
      end
      MODE_MANUAL: begin
        res.lin_cmd = lin_man;
        res.ang_cmd = ang_man;
        priority if (!mid.all_ok) mode_nxt = MODE_IDLE;
        else if (mid.sw)          mode_nxt = MODE_AUTO;
        else                      mode_nxt = MODE_MANUAL;
      end
      MODE_AUTO: begin
        res.lin_cmd = mid.auto_lin;
        res.ang_cmd = mid.auto_ang;
        priority if (!mid.all_ok) mode_nxt = MODE_IDLE;
        else if (mid.estop) begin
          mode_nxt       = MODE_STOP;
          stop_start_nxt = mid.now_ms;
        end else if (!mid.sw) mode_nxt = MODE_MANUAL;
        else                  mode_nxt = MODE_AUTO;
      end
      MODE_STOP: begin
        res.lin_cmd = {{5{cfg.rev_speed[10]}}, cfg.rev_speed};
        // no connection check here: a dropped controller reads as released
        priority if (elapsed > cfg.stop_hold) mode_nxt = MODE_AUTO;
        else if (!mid.sw)                      mode_nxt = MODE_MANUAL;
        else                                   mode_nxt = MODE_STOP;
      end
      default: ;
    endcase

    res.mode_now     = mode_nxt;
    res.mode_changed = (mode_nxt != mode_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      stop_start_r <= '0;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      stop_start_r <= stop_start_nxt;
    end
  end

  assign mode_q = mode_r;

endmodule

`default_nettype wire

// ===== hw/rtl/robot_drive_mode_controller.sv =====
// Top level of the robot drive mode controller: input register, product
// stage, mode stage and result register. Depends on rdmc_pkg, rdmc_if,
// rdmc_cfg, rdmc_prep, rdmc_div127 and rdmc_fsm.
//
// One beat in per control tick, one result beat out per input beat. The block
// is a three register pipeline (input, product, result) and accepts a new beat
// every cycle unless the result side stalls. The mode register is read and
// written in the last stage only, so back-to-back ticks see each other's mode
// transitions in order. Stick scaling is a multiply by the configured maximum
// in the product stage and a multiply by the reciprocal of 127 in the mode
// stage. Any stall on the result side backs up through the stages without
// losing beats. Configuration is to be written only while no beat is in
// flight; the block itself does not enforce this.
`default_nettype none

module robot_drive_mode_controller
  import rdmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rdmc_in_if.sink                    in_ch,
  rdmc_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t in_r;
  logic     in_v_r;
  mid_t     mid_nxt, mid_r;
  logic     mid_v_r;
  res_t     res_nxt, out_r;
  logic     out_v_r;
  mode_t    fsm_mode;

  logic out_adv, mid_ready, in_ready, fsm_en;
  logic [QUO_W-1:0] lin_q, ang_q;

  rdmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg)
  );

  assign in_item.now_ms               = in_ch.now_ms;
  assign in_item.controller_connected = in_ch.controller_connected;
  assign in_item.link_ok              = in_ch.link_ok;
  assign in_item.mode_switch          = in_ch.mode_switch;
  assign in_item.stick_lin            = in_ch.stick_lin;
  assign in_item.stick_turn           = in_ch.stick_turn;
  assign in_item.auto_lin_mm_s        = in_ch.auto_lin_mm_s;
  assign in_item.auto_ang_mrad_s      = in_ch.auto_ang_mrad_s;
  assign in_item.range_right_mm       = in_ch.range_right_mm;
  assign in_item.range_center_mm      = in_ch.range_center_mm;
  assign in_item.range_left_mm        = in_ch.range_left_mm;

  // stage handshakes, result side first
  assign out_adv   = !out_v_r || out_ch.ready;
  assign mid_ready = !mid_v_r || out_adv;
  assign in_ready  = !in_v_r  || mid_ready;
  assign fsm_en    = mid_v_r && out_adv;

  assign in_ch.ready = in_ready;

  rdmc_prep u_prep (
    .item (in_r),
    .cfg  (cfg),
    .mid  (mid_nxt)
  );

  rdmc_div127 u_div_lin (
    .arg (mid_r.lin_arg),
    .quo (lin_q)
  );

  rdmc_div127 u_div_ang (
    .arg (mid_r.ang_arg),
    .quo (ang_q)
  );

  rdmc_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (fsm_en),
    .mid    (mid_r),
    .cfg    (cfg),
    .lin_q  (lin_q),
    .ang_q  (ang_q),
    .res    (res_nxt),
    .mode_q (fsm_mode)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready)  in_v_r  <= in_ch.valid;
      if (mid_ready) mid_v_r <= in_v_r;
      if (out_adv)   out_v_r <= mid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready)  in_r  <= in_item;
    if (mid_ready) mid_r <= mid_nxt;
    if (out_adv)   out_r <= res_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.mode_now       = out_r.mode_now;
  assign out_ch.mode_changed   = out_r.mode_changed;
  assign out_ch.lin_cmd_mm_s   = out_r.lin_cmd;
  assign out_ch.ang_cmd_mrad_s = out_r.ang_cmd;

  // mode only moves when a beat leaves the mode stage
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fsm_en |=> $stable(fsm_mode))
    else $error("mode changed without a beat in the mode stage");

  // the result register and the mode register are loaded together
  a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
    fsm_en |=> (out_r.mode_now == fsm_mode))
    else $error("result mode differs from held mode");

  // a blocked input stage keeps its beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !mid_ready) |=> (in_v_r && $stable(in_r)))
    else $error("input stage beat lost under stall");

endmodule

`default_nettype wire
